FILE: rtl/core/lirc_pkg.sv
// ----------------------------------------------------------------------------
// lirc_pkg
// Shared types, codes and constants of the lock-in reference and capture block.
// ----------------------------------------------------------------------------
package lirc_pkg;

    localparam int TABLE_DEPTH_DEF = 8192;
    localparam int HALF_DEPTH_DEF  = 512;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int DAC_BITS_DEF    = 10;

    localparam int OP_W       = 2;
    localparam int TIME_W     = 32;
    localparam int ADDR_W     = 13;
    localparam int PHASE_W    = 13;
    localparam int PERIOD_W   = 32;
    localparam int FACTOR_W   = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam int FRAC_SHIFT = 8;
    localparam int DVD_W      = TIME_W + FRAC_SHIFT;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1868613;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 48'd4819670566;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_LOOKUP,
        ST_LOAD,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_TICK,
        RES_READ
    } res_kind_t;

    typedef struct packed {
        logic      capture_in;
        logic      div_step;
        logic      mul_lo;
        logic      mul_hi;
        logic      round;
        logic      lookup;
        logic      start;
        logic      table_wr;
        logic      store_rd;
        logic      out_load;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage

FILE: rtl/core/lirc_ctrl.sv
// ----------------------------------------------------------------------------
// lirc_ctrl
// Request sequencer: decodes each request, steps running ticks through divide,
// multiply, round and lookup, and hands each result to the output register.
// ----------------------------------------------------------------------------
module lirc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [lirc_pkg::OP_W-1:0] op,
    input  logic                    run,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  lirc_pkg::dp_status_t    status,
    output lirc_pkg::ctrl_cmd_t     cmd
);

    lirc_pkg::state_t    state_reg, state_next;
    lirc_pkg::res_kind_t kind_reg, kind_next;
    logic                prev_run_reg, prev_run_next;
    logic                starting_reg, starting_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                accept;
    logic                out_free;

    assign accept   = s_tvalid && (state_reg == lirc_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == lirc_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lirc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (lirc_pkg::op_t'(op))
                        lirc_pkg::OP_TICK: begin
                            state_next = run ? lirc_pkg::ST_DIVIDE : lirc_pkg::ST_FINISH;
                        end
                        lirc_pkg::OP_LOAD: state_next = lirc_pkg::ST_LOAD;
                        lirc_pkg::OP_READ: state_next = lirc_pkg::ST_READ;
                        default:           state_next = lirc_pkg::ST_FINISH;
                    endcase
                end
            end
            lirc_pkg::ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = lirc_pkg::ST_MUL_LO;
                end
            end
            lirc_pkg::ST_MUL_LO: state_next = lirc_pkg::ST_MUL_HI;
            lirc_pkg::ST_MUL_HI: state_next = lirc_pkg::ST_ROUND;
            lirc_pkg::ST_ROUND:  state_next = lirc_pkg::ST_LOOKUP;
            lirc_pkg::ST_LOOKUP: state_next = lirc_pkg::ST_FINISH;
            lirc_pkg::ST_LOAD:   state_next = lirc_pkg::ST_FINISH;
            lirc_pkg::ST_READ:   state_next = lirc_pkg::ST_FINISH;
            lirc_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = lirc_pkg::ST_IDLE;
                end
            end
            default: state_next = lirc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        kind_next     = kind_reg;
        prev_run_next = prev_run_reg;
        starting_next = starting_reg;
        if (accept) begin
            case (lirc_pkg::op_t'(op))
                lirc_pkg::OP_TICK: begin
                    kind_next     = run ? lirc_pkg::RES_TICK : lirc_pkg::RES_ZERO;
                    prev_run_next = run;
                    if (run && !prev_run_reg) begin
                        starting_next = 1'b1;
                    end
                end
                lirc_pkg::OP_READ: kind_next = lirc_pkg::RES_READ;
                default:           kind_next = lirc_pkg::RES_ZERO;
            endcase
        end
        if (state_reg == lirc_pkg::ST_LOOKUP) begin
            starting_next = 1'b0;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.capture_in = accept;
        cmd.div_step   = (state_reg == lirc_pkg::ST_DIVIDE);
        cmd.mul_lo     = (state_reg == lirc_pkg::ST_MUL_LO);
        cmd.mul_hi     = (state_reg == lirc_pkg::ST_MUL_HI);
        cmd.round      = (state_reg == lirc_pkg::ST_ROUND);
        cmd.lookup     = (state_reg == lirc_pkg::ST_LOOKUP);
        cmd.start      = starting_reg;
        cmd.table_wr   = (state_reg == lirc_pkg::ST_LOAD);
        cmd.store_rd   = (state_reg == lirc_pkg::ST_READ);
        cmd.out_load   = (state_reg == lirc_pkg::ST_FINISH) && out_free;
        cmd.res_kind   = kind_reg;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lirc_pkg::ST_IDLE;
            kind_reg     <= lirc_pkg::RES_ZERO;
            prev_run_reg <= 1'b0;
            starting_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            prev_run_reg <= prev_run_next;
            starting_reg <= starting_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: rtl/core/lirc_dp.sv
// ----------------------------------------------------------------------------
// lirc_dp
// Datapath: configuration registers, bit-serial modulo, two-part phase
// multiply with rounding, cosine table, capture stores and output register.
// ----------------------------------------------------------------------------
module lirc_dp #(
    parameter int TABLE_DEPTH = lirc_pkg::TABLE_DEPTH_DEF,
    parameter int HALF_DEPTH  = lirc_pkg::HALF_DEPTH_DEF,
    parameter int SAMPLE_BITS = lirc_pkg::SAMPLE_BITS_DEF,
    parameter int DAC_BITS    = lirc_pkg::DAC_BITS_DEF,
    parameter int OUT_W       = 88
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lirc_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [lirc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [lirc_pkg::TIME_W-1:0]      time_us,
    input  logic [SAMPLE_BITS-1:0]           adc_sample,
    input  logic [lirc_pkg::ADDR_W-1:0]      address,
    input  logic [DAC_BITS-1:0]              table_word,
    input  lirc_pkg::ctrl_cmd_t              cmd,
    output lirc_pkg::dp_status_t             status,
    output logic [OUT_W-1:0]                 m_tdata
);

    localparam int TBL_AW       = $clog2(TABLE_DEPTH);
    localparam int STORE_DEPTH  = 2 * HALF_DEPTH;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int PERIOD_W     = lirc_pkg::PERIOD_W;
    localparam int TIME_W       = lirc_pkg::TIME_W;
    localparam int PHASE_W      = lirc_pkg::PHASE_W;
    localparam int MID_W        = lirc_pkg::FACTOR_W + 1;
    localparam int IDX_W        = MID_W - lirc_pkg::FRAC_SHIFT;
    localparam int PHASE_LSB    = DAC_BITS;
    localparam int FIRST_BIT    = PHASE_LSB + PHASE_W;
    localparam int SECOND_BIT   = FIRST_BIT + 1;
    localparam int RD_TIME_LSB  = SECOND_BIT + 1;
    localparam int RD_PHASE_LSB = RD_TIME_LSB + TIME_W;
    localparam int RD_SMP_LSB   = RD_PHASE_LSB + PHASE_W;

    logic [PERIOD_W-1:0]            period_reg;
    logic [lirc_pkg::FACTOR_W-1:0]  factor_reg;

    logic [TIME_W-1:0]              time_reg;
    logic [SAMPLE_BITS-1:0]         smp_reg;
    logic [lirc_pkg::ADDR_W-1:0]    addr_reg;
    logic [DAC_BITS-1:0]            word_reg;

    logic [lirc_pkg::DVD_W-1:0]     dvd_reg;
    logic [PERIOD_W-1:0]            rem_reg, rem_next;
    logic [lirc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [PERIOD_W:0]              div_shift;
    logic [PERIOD_W:0]              div_sub;
    logic [PERIOD_W-1:0]            rem_eff;

    logic [63:0]                    plo_reg;
    logic [lirc_pkg::FACTOR_W-1:0]  phi_reg;
    logic [MID_W-1:0]               mid;
    logic [IDX_W-1:0]               idx;
    logic [TBL_AW-1:0]              phase_reg, phase_next;

    logic [STORE_AW-1:0]            rec_reg, rec_next;
    logic [STORE_AW-1:0]            smp_ptr_reg, smp_ptr_next;
    logic [STORE_AW:0]              rec_new, smp_new;
    logic [STORE_AW-1:0]            wr_rec, wr_smp;
    logic                           first_next, second_next;
    logic                           first_reg, second_reg;

    logic [DAC_BITS-1:0]            dac_rd_reg;
    logic [TIME_W-1:0]              time_rd_reg;
    logic [TBL_AW-1:0]              phase_rd_reg;
    logic [SAMPLE_BITS-1:0]         smp_rd_reg;
    logic                           rd_ok_reg;

    logic [31:0]                    addr_ext;
    logic                           ld_ok;
    logic [TBL_AW-1:0]              ld_idx;
    logic [STORE_AW-1:0]            rd_idx;

    logic [OUT_W-1:0]               out_next;
    logic [OUT_W-1:0]               m_tdata_reg;

    logic [DAC_BITS-1:0]            cos_mem   [TABLE_DEPTH];
    logic [TIME_W-1:0]              time_mem  [STORE_DEPTH];
    logic [TBL_AW-1:0]              phase_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0]         smp_mem   [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= lirc_pkg::PERIOD_RESET;
            factor_reg <= lirc_pkg::FACTOR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                lirc_pkg::CFG_PERIOD: period_reg <= cfg_wr_data[PERIOD_W-1:0];
                lirc_pkg::CFG_FACTOR: factor_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // restoring divide, one quotient bit per step
    assign div_shift = {rem_reg, dvd_reg[lirc_pkg::DVD_W-1]};
    assign div_sub   = div_shift - {1'b0, period_reg};
    assign rem_next  = (div_shift >= {1'b0, period_reg}) ? div_sub[PERIOD_W-1:0]
                                                          : div_shift[PERIOD_W-1:0];
    assign rem_eff   = (period_reg == '0) ? '0 : rem_reg;
    assign status.div_last =
        (cnt_reg == lirc_pkg::DIV_CNT_W'(lirc_pkg::DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.capture_in) begin
            time_reg <= time_us;
            smp_reg  <= adc_sample;
            addr_reg <= address;
            word_reg <= table_word;
            dvd_reg  <= {time_us, {lirc_pkg::FRAC_SHIFT{1'b0}}};
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[lirc_pkg::DVD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            plo_reg <= 64'(rem_eff) * 64'(factor_reg[31:0]);
        end
        if (cmd.mul_hi) begin
            phi_reg <= lirc_pkg::FACTOR_W'(rem_eff) *
                       lirc_pkg::FACTOR_W'(factor_reg[lirc_pkg::FACTOR_W-1:32]);
        end
    end

    // round half up at bit 40, saturate to the table
    assign mid = MID_W'(plo_reg[63:32]) + MID_W'(phi_reg) + MID_W'(128);
    assign idx = mid[MID_W-1:lirc_pkg::FRAC_SHIFT];
    assign phase_next = (idx > IDX_W'(TABLE_DEPTH - 1)) ? TBL_AW'(TABLE_DEPTH - 1)
                                                        : idx[TBL_AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            phase_reg <= phase_next;
        end
    end

    assign wr_rec  = cmd.start ? '0 : rec_reg;
    assign wr_smp  = cmd.start ? '0 : smp_ptr_reg;
    assign rec_new = cmd.start ? (STORE_AW + 1)'(1) : {1'b0, rec_reg} + 1'b1;
    assign smp_new = cmd.start ? '0 : {1'b0, smp_ptr_reg} + 1'b1;

    always_comb begin
        first_next   = (rec_new == (STORE_AW + 1)'(HALF_DEPTH));
        second_next  = !first_next && (rec_new == (STORE_AW + 1)'(STORE_DEPTH));
        rec_next     = second_next ? '0 : rec_new[STORE_AW-1:0];
        smp_ptr_next = (smp_new == (STORE_AW + 1)'(STORE_DEPTH)) ? '0
                                                                  : smp_new[STORE_AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg     <= '0;
            smp_ptr_reg <= '0;
        end else if (cmd.lookup) begin
            rec_reg     <= rec_next;
            smp_ptr_reg <= smp_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            dac_rd_reg <= cos_mem[phase_reg];
        end
    end

    assign addr_ext = {{(32 - lirc_pkg::ADDR_W){1'b0}}, addr_reg};
    assign ld_ok    = (addr_ext < 32'(TABLE_DEPTH));
    assign ld_idx   = TBL_AW'(addr_ext);
    assign rd_idx   = STORE_AW'(addr_ext);

    always_ff @(posedge aclk) begin
        if (cmd.table_wr && ld_ok) begin
            cos_mem[ld_idx] <= word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            time_mem[wr_rec]  <= time_reg;
            phase_mem[wr_rec] <= phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            smp_mem[wr_smp] <= smp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_rd) begin
            time_rd_reg  <= time_mem[rd_idx];
            phase_rd_reg <= phase_mem[rd_idx];
            smp_rd_reg   <= smp_mem[rd_idx];
            rd_ok_reg    <= (addr_ext < 32'(STORE_DEPTH));
        end
    end

    always_comb begin
        out_next = '0;
        case (cmd.res_kind)
            lirc_pkg::RES_TICK: begin
                out_next[DAC_BITS-1:0]        = dac_rd_reg;
                out_next[PHASE_LSB +: PHASE_W] = PHASE_W'({{PHASE_W{1'b0}}, phase_reg});
                out_next[FIRST_BIT]           = first_reg;
                out_next[SECOND_BIT]          = second_reg;
            end
            lirc_pkg::RES_READ: begin
                if (rd_ok_reg) begin
                    out_next[RD_TIME_LSB +: TIME_W]  = time_rd_reg;
                    out_next[RD_PHASE_LSB +: PHASE_W] =
                        PHASE_W'({{PHASE_W{1'b0}}, phase_rd_reg});
                    out_next[RD_SMP_LSB +: SAMPLE_BITS] = smp_rd_reg;
                end
            end
            default: out_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= out_next;
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

FILE: rtl/core/lockin_reference_and_capture_top.sv
// ----------------------------------------------------------------------------
// lockin_reference_and_capture_top
// Lock-in reference generator with cosine lookup and double-buffered capture.
//
// Requests arrive on the s_ stream; s_tuser carries the operation (tick, table
// load, capture read). Every request yields exactly one result on the m_
// stream. Configuration (period, index factor) is written through the cfg_
// port, by the user only while no request is in flight; the block does not
// enforce this. A running tick goes from acceptance to m_tvalid through the
// bit-serial modulo unit (one remainder bit per cycle over time_us * 256), the
// low and high multiply, rounding, the table lookup and the output load. Loads
// and reads pass a table write or store read, stopped ticks go straight to the
// output load; the block then returns to idle before taking the next request.
// The output register holds a finished result while m_tready is low; the block
// can accept the next request meanwhile and stalls only when that request's
// result is ready and the output register is still full.
// Reset clears the sequencer, pointers and run tracking and restores the
// configuration defaults; the cosine table and capture stores are not cleared.
// ----------------------------------------------------------------------------
module lockin_reference_and_capture_top #(
    parameter int TABLE_DEPTH = lirc_pkg::TABLE_DEPTH_DEF,
    parameter int HALF_DEPTH  = lirc_pkg::HALF_DEPTH_DEF,
    parameter int SAMPLE_BITS = lirc_pkg::SAMPLE_BITS_DEF,
    parameter int DAC_BITS    = lirc_pkg::DAC_BITS_DEF,
    localparam int IN_BITS    = 1 + lirc_pkg::TIME_W + SAMPLE_BITS + lirc_pkg::ADDR_W
                                + DAC_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = DAC_BITS + lirc_pkg::PHASE_W + 2 + lirc_pkg::TIME_W
                                + lirc_pkg::PHASE_W + SAMPLE_BITS,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lirc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [lirc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // run, time_us, adc_sample, address, table_word
    input  logic [IN_W-1:0]                 s_tdata,
    // operation
    input  logic [lirc_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // dac_code, phase_index, first_half_full, second_half_full,
    // read_time, read_phase, read_sample
    output logic [OUT_W-1:0]                m_tdata
);

    localparam int TIME_LSB = 1;
    localparam int SMP_LSB  = TIME_LSB + lirc_pkg::TIME_W;
    localparam int ADDR_LSB = SMP_LSB + SAMPLE_BITS;
    localparam int WORD_LSB = ADDR_LSB + lirc_pkg::ADDR_W;

    lirc_pkg::ctrl_cmd_t  cmd;
    lirc_pkg::dp_status_t status;

    lirc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .run      (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lirc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HALF_DEPTH  (HALF_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DAC_BITS    (DAC_BITS),
        .OUT_W       (OUT_W)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .time_us      (s_tdata[TIME_LSB +: lirc_pkg::TIME_W]),
        .adc_sample   (s_tdata[SMP_LSB +: SAMPLE_BITS]),
        .address      (s_tdata[ADDR_LSB +: lirc_pkg::ADDR_W]),
        .table_word   (s_tdata[WORD_LSB +: DAC_BITS]),
        .cmd          (cmd),
        .status       (status),
        .m_tdata      (m_tdata)
    );

endmodule

FILE: rtl/core/lirc_checker.sv
// ----------------------------------------------------------------------------
// lirc_checker
// Port-level checks of the lock-in reference and capture block, bound to the
// top level.
// ----------------------------------------------------------------------------
module lirc_checker #(
    parameter int DAC_BITS    = lirc_pkg::DAC_BITS_DEF,
    parameter int OUT_W       = 88
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int PHASE_LSB   = DAC_BITS;
    localparam int FIRST_BIT   = PHASE_LSB + lirc_pkg::PHASE_W;
    localparam int SECOND_BIT  = FIRST_BIT + 1;
    localparam int RD_TIME_LSB = SECOND_BIT + 1;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous request still in work");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[FIRST_BIT] && m_tdata[SECOND_BIT]))
        else $error("both capture halves flagged at once");

    a_tick_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[PHASE_LSB +: lirc_pkg::PHASE_W] != '0)
        |-> m_tdata[RD_TIME_LSB +: lirc_pkg::TIME_W] == '0)
        else $error("tick result carries capture read data");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind lockin_reference_and_capture_top lirc_checker #(
    .DAC_BITS    (DAC_BITS),
    .OUT_W       (OUT_W)
) u_lirc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
